// ===== hw/rtl/afa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afa_pkg: shared types and constants of the animation frame advance unit
// Operation codes, the time width and the control/status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package afa_pkg;

    // operation codes of an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TIME  = 1'b1;

    // width of the time field and of the serial modulo counter
    localparam int TIME_W    = 31;
    localparam int DIV_CNT_W = $clog2(TIME_W);

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic wr_update;
        logic restart;
        logic div_time_start;
        logic div_frame_start;
        logic load_rem;
        logic walk_prime;
        logic walk_step;
        logic load_out;
    } afa_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_is_time;
        logic clr_last;
        logic restart_cond;
        logic time_back;
        logic div_done;
        logic need_frame_mod;
        logic walk_stop;
    } afa_status_t;

endpackage : afa_pkg
`default_nettype wire

// ===== hw/rtl/afa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module afa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : afa_ram
`default_nettype wire

// ===== hw/rtl/afa_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afa_mod_unit: serial restoring modulo
// Computes dividend mod divisor one dividend bit per cycle over all TIME_W bits.
// ----------------------------------------------------------------------------
module afa_mod_unit
    import afa_pkg::*;
#(
    parameter int DIVISOR_W = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [TIME_W-1:0]    dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [DIVISOR_W-1:0]      remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    dividend_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W-1:0] rem_next;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, dividend_reg[TIME_W-1]};
        if (shifted >= {1'b0, divisor_reg})
        begin
            rem_next = DIVISOR_W'(shifted - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = DIVISOR_W'(shifted);
        end
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(TIME_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (busy_reg)
        begin
            dividend_reg <= {dividend_reg[TIME_W-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // a new operation only starts on an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modulo unit started while busy");

endmodule : afa_mod_unit
`default_nettype wire

// ===== hw/rtl/afa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afa_ctrl: controller of the animation frame advance unit
// Sequences the clearing pass, delay writes, the modulo and the frame walk,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module afa_ctrl
    import afa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire afa_status_t status,
    output afa_cmd_t         cmd
);

    typedef enum logic [8:0] {
        S_CLEAR      = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_WR_UPDATE  = 9'b000000100,
        S_TIME_CHECK = 9'b000001000,
        S_MOD_TIME   = 9'b000010000,
        S_MOD_FRAME  = 9'b000100000,
        S_WALK_PRIME = 9'b001000000,
        S_WALK       = 9'b010000000,
        S_RESULT     = 9'b100000000
    } afa_state_t;

    afa_state_t state_reg;
    afa_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_is_time ? S_TIME_CHECK : S_WR_UPDATE;
                end
            end
            S_WR_UPDATE:
            begin
                cmd.wr_update = 1'b1;
                state_next    = S_RESULT;
            end
            S_TIME_CHECK:
            begin
                if (status.restart_cond)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_RESULT;
                end
                else if (status.time_back)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.div_time_start = 1'b1;
                    state_next         = S_MOD_TIME;
                end
            end
            S_MOD_TIME:
            begin
                if (status.div_done)
                begin
                    cmd.load_rem = 1'b1;
                    if (status.need_frame_mod)
                    begin
                        cmd.div_frame_start = 1'b1;
                        state_next          = S_MOD_FRAME;
                    end
                    else
                    begin
                        state_next = S_WALK_PRIME;
                    end
                end
            end
            S_MOD_FRAME:
            begin
                if (status.div_done)
                begin
                    state_next = S_WALK_PRIME;
                end
            end
            S_WALK_PRIME:
            begin
                cmd.walk_prime = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_stop)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result never overwrites one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

endmodule : afa_ctrl
`default_nettype wire

// ===== hw/rtl/afa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afa_datapath: datapath of the animation frame advance unit
// Delay table, running total, frame state, the shared modulo unit, the frame
// walk and the result register.
// ----------------------------------------------------------------------------
module afa_datapath
    import afa_pkg::*;
#(
    parameter int MAX_FRAMES = 256,
    parameter int DELAY_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [8:0]        cfg_data,
    input  wire logic              operation,
    input  wire logic [7:0]        frame_index,
    input  wire logic [15:0]       frame_delay,
    input  wire logic [TIME_W-1:0] time_now,
    output logic      [7:0]        shown_frame,
    output logic                   frame_changed,
    input  wire afa_cmd_t          cmd,
    output afa_status_t            status
);

    localparam int FI_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int TOT_W = DELAY_BITS + $clog2(MAX_FRAMES + 1);
    localparam int CW    = (FI_W + 1 > 9) ? FI_W + 1 : 9;
    localparam int DIN_W = (DELAY_BITS < 16) ? DELAY_BITS : 16;

    // configuration and frame state
    logic [8:0]            frame_count_reg;
    logic [TOT_W-1:0]      delay_total_reg;
    logic [FI_W-1:0]       current_frame_reg;
    logic [TIME_W-1:0]     anchor_time_reg;
    logic                  started_reg;
    logic [FI_W-1:0]       clr_addr_reg;

    // captured item and work registers
    logic                  op_reg;
    logic [7:0]            idx_reg;
    logic [DELAY_BITS-1:0] dly_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [FI_W-1:0]       old_frame_reg;
    logic [TOT_W-1:0]      rem_reg;
    logic [FI_W-1:0]       rd_frame_reg;
    logic [8:0]            step_cnt_reg;
    logic [7:0]            shown_frame_reg;
    logic                  frame_changed_reg;

    logic [8:0]            n_val;
    logic                  wr_in_range;
    logic [CW-1:0]         frame_plus;
    logic [FI_W-1:0]       first_frame;
    logic [FI_W-1:0]       walk_next;
    logic [TOT_W-1:0]      d_ext;
    logic                  walk_fits;
    logic [TOT_W-1:0]      rem_after;

    logic                  ram_we;
    logic [FI_W-1:0]       ram_waddr;
    logic [DELAY_BITS-1:0] ram_wdata;
    logic [FI_W-1:0]       ram_raddr;
    logic [DELAY_BITS-1:0] ram_rdata;

    logic                  div_start;
    logic [TIME_W-1:0]     div_dividend;
    logic [TOT_W-1:0]      div_divisor;
    logic                  div_done;
    logic [TOT_W-1:0]      div_rem;

    // next frame in the ring for a frame already below the count
    function automatic logic [FI_W-1:0] ring_next(input logic [FI_W-1:0] f,
                                                  input logic [8:0] n);
        logic [CW-1:0] fp;
        fp = CW'(f) + CW'(1);
        return (fp == CW'(n)) ? '0 : FI_W'(fp);
    endfunction

    // effective frame count
    assign n_val = (32'(frame_count_reg) > 32'(MAX_FRAMES)) ? 9'(MAX_FRAMES)
                                                             : frame_count_reg;

    assign wr_in_range = CW'(idx_reg) < CW'(n_val);
    assign frame_plus  = CW'(current_frame_reg) + CW'(1);

    // status toward the controller
    always_comb
    begin
        status                = '0;
        status.in_is_time     = (operation == OP_TIME);
        status.clr_last       = (clr_addr_reg == FI_W'(MAX_FRAMES - 1));
        status.restart_cond   = !started_reg || (n_val == '0) || (delay_total_reg == '0);
        status.time_back      = now_reg < anchor_time_reg;
        status.div_done       = div_done;
        status.need_frame_mod = frame_plus > CW'(n_val);
        status.walk_stop      = !walk_fits || (rem_after == '0)
                                || ((step_cnt_reg + 9'd1) == n_val);
    end

    // walk step evaluation on the delay read last cycle
    assign d_ext       = TOT_W'(ram_rdata);
    assign walk_fits   = d_ext <= rem_reg;
    assign rem_after   = rem_reg - d_ext;
    assign walk_next   = ring_next(rd_frame_reg, n_val);
    assign first_frame = status.need_frame_mod ? FI_W'(div_rem)
                                               : ring_next(current_frame_reg, n_val);

    // table read address: walk runs one frame ahead of the evaluation
    always_comb
    begin
        priority if (cmd.walk_prime)
        begin
            ram_raddr = first_frame;
        end
        else if (cmd.walk_step)
        begin
            ram_raddr = walk_next;
        end
        else
        begin
            ram_raddr = FI_W'(frame_index);
        end
    end

    // table write port: clearing pass or delay write
    always_comb
    begin
        priority if (cmd.clr_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.wr_update && wr_in_range;
            ram_waddr = FI_W'(idx_reg);
            ram_wdata = dly_reg;
        end
    end

    afa_ram #(
        .WIDTH (DELAY_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared modulo: elapsed time by the total, or a stale frame by the count
    assign div_start    = cmd.div_time_start || cmd.div_frame_start;
    assign div_dividend = cmd.div_frame_start ? TIME_W'(frame_plus)
                                              : (now_reg - anchor_time_reg);
    assign div_divisor  = cmd.div_frame_start ? TOT_W'(n_val) : delay_total_reg;

    afa_mod_unit #(
        .DIVISOR_W (TOT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // frame state, total and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= '0;
            delay_total_reg   <= '0;
            current_frame_reg <= '0;
            anchor_time_reg   <= '0;
            started_reg       <= 1'b0;
            clr_addr_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                frame_count_reg <= cfg_data;
            end
            if (cmd.clr_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.wr_update && wr_in_range)
            begin
                delay_total_reg <= delay_total_reg - TOT_W'(ram_rdata) + TOT_W'(dly_reg);
            end
            if (cmd.restart)
            begin
                current_frame_reg <= '0;
                anchor_time_reg   <= now_reg;
                started_reg       <= 1'b1;
            end
            if (cmd.walk_step && walk_fits)
            begin
                current_frame_reg <= rd_frame_reg;
                anchor_time_reg   <= now_reg;
            end
        end
    end

    // item capture, walk registers and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= operation;
            idx_reg       <= frame_index;
            dly_reg       <= DELAY_BITS'(frame_delay[DIN_W-1:0]);
            now_reg       <= time_now;
            old_frame_reg <= current_frame_reg;
        end
        if (cmd.load_rem)
        begin
            rem_reg <= div_rem;
        end
        if (cmd.walk_prime)
        begin
            rd_frame_reg <= first_frame;
            step_cnt_reg <= '0;
        end
        if (cmd.walk_step)
        begin
            rd_frame_reg <= walk_next;
            step_cnt_reg <= step_cnt_reg + 9'd1;
            if (walk_fits)
            begin
                rem_reg <= rem_after;
            end
        end
        if (cmd.load_out)
        begin
            shown_frame_reg   <= 8'(current_frame_reg);
            frame_changed_reg <= (op_reg == OP_TIME) && (current_frame_reg != old_frame_reg);
        end
    end

    assign shown_frame   = shown_frame_reg;
    assign frame_changed = frame_changed_reg;

    // the walk only reads frames below the count
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (CW'(rd_frame_reg) < CW'(n_val)))
        else $error("walk visited a frame past the count");

    // a frame that fits re-anchors to the item time
    a_walk_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk_step && walk_fits) |=> (anchor_time_reg == $past(now_reg)))
        else $error("walk step did not re-anchor");

endmodule : afa_datapath
`default_nettype wire

// ===== hw/rtl/animation_frame_advance_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// animation_frame_advance_unit: animation frame timing
// Keeps per-frame delays with their total and picks the frame to show at a
// given time.
// ----------------------------------------------------------------------------
// After reset the unit clears its delay table entry by entry and takes no item
// meanwhile; frame_count writes are taken at any time. One item is worked at
// a time and yields one result. A delay write goes through a table read, the
// update and the result. A time item that restarts the animation, or whose
// time lies before the anchor, ends after the time check with the result. Any
// other time item runs the serial modulo of the elapsed time by the delay
// total, then walks frame by frame, one delay table read a cycle, over at most
// the frame count of frames; when the current frame lies at or past a reduced
// frame count, a second modulo finds the next frame first. The next item is
// taken while the previous result waits at the output.
// ----------------------------------------------------------------------------
module animation_frame_advance_unit
    import afa_pkg::*;
#(
    parameter int MAX_FRAMES = 256,
    parameter int DELAY_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [8:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              operation,
    input  wire logic [7:0]        frame_index,
    input  wire logic [15:0]       frame_delay,
    input  wire logic [TIME_W-1:0] time_now,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [7:0]        shown_frame,
    output logic                   frame_changed
);

    afa_cmd_t    cmd;
    afa_status_t status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    afa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    afa_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .DELAY_BITS (DELAY_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .frame_index   (frame_index),
        .frame_delay   (frame_delay),
        .time_now      (time_now),
        .shown_frame   (shown_frame),
        .frame_changed (frame_changed),
        .cmd           (cmd),
        .status        (status)
    );

endmodule : animation_frame_advance_unit
`default_nettype wire

// ===== tb/animation_frame_advance_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// animation_frame_advance_unit_tb: self-checking bench of the frame advance unit
// A stimulus table of delay writes, time items and frame_count changes runs
// first. Random phases follow, each loading a delay set and advancing time.
// A shadow copy of the delay table, total, current frame and anchor predicts
// untyped results. Results are compared in order with random item/output stalls.
// ----------------------------------------------------------------------------
module animation_frame_advance_unit_tb
    import afa_pkg::*;
();

    localparam int FRAME_SLOTS   = 256;
    localparam int ITEM_TARGET   = 1650;
    localparam int STALL_LIMIT   = 5000;
    localparam int IDLE_PCT      = 38;
    localparam int DIRECTED_ROWS = 27;
    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    // one line of the stimulus table; typed rows carry their own expectation
    typedef struct packed {
        row_kind_t   kind;
        logic [8:0]  cfg_value;
        logic        op;
        logic [7:0]  idx;
        logic [15:0] dly;
        logic [30:0] tnow;
        logic        typed;
        logic [7:0]  exp_frame;
        logic        exp_changed;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] frame;
        logic       changed;
    } frame_result_t;

    // directed stimulus: extremes, out-of-range writes, zero delays, shrunk and
    // oversized frame counts, time running backwards
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      31'd100,       1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd0,   16'hFFFF,   31'd0,         1'b1, 8'd0, 1'b0},
        '{ROW_CFG,  9'd4,   OP_WRITE, 8'd0,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      31'd105,       1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd0,   16'd10,     31'd0,         1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd1,   16'd20,     31'd0,         1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd2,   16'd0,      31'd0,         1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd3,   16'hFFFF,   31'd0,         1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd255, 16'd5,      31'd0,         1'b1, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      31'd115,       1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      31'd140,       1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      31'd50,        1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      TIME_MAX,      1'b0, 8'd0, 1'b0},
        '{ROW_CFG,  9'd2,   OP_WRITE, 8'd0,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      TIME_MAX,      1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd1,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      TIME_MAX,      1'b0, 8'd0, 1'b0},
        '{ROW_CFG,  9'd511, OP_WRITE, 8'd0,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd255, 16'hFFFF,   31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'h55,  16'h5555,   31'h5555_5555, 1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'hAA,  16'hAAAA,   31'h2AAA_AAAA, 1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      TIME_MAX,      1'b0, 8'd0, 1'b0},
        '{ROW_CFG,  9'd1,   OP_WRITE, 8'd0,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      TIME_MAX,      1'b0, 8'd0, 1'b0},
        '{ROW_CFG,  9'd0,   OP_WRITE, 8'd0,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_TIME,  8'd0,   16'd0,      31'd0,         1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, 9'd0,   OP_WRITE, 8'd0,   16'd1,      31'd0,         1'b0, 8'd0, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [8:0]        cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [7:0]        frame_index;
    logic [15:0]       frame_delay;
    logic [TIME_W-1:0] time_now;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        shown_frame;
    logic              frame_changed;

    // shadow state of the frame timing
    logic [15:0]       delay_mem [FRAME_SLOTS];
    int unsigned       delay_sum;
    logic [7:0]        shadow_frame;
    logic [30:0]       anchor_at;
    bit                running;
    logic [8:0]        frame_count_reg;

    frame_result_t     expected_frames [$];
    int                errors;
    int                items_sent;
    bit                no_idle;

    animation_frame_advance_unit #(
        .MAX_FRAMES(FRAME_SLOTS),
        .DELAY_BITS(16)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .frame_index  (frame_index),
        .frame_delay  (frame_delay),
        .time_now     (time_now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .shown_frame  (shown_frame),
        .frame_changed(frame_changed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // apply one item to the shadow state and return the frame it leaves shown
    function automatic frame_result_t advance_frame(input logic op, input logic [7:0] idx,
                                                    input logic [15:0] dly,
                                                    input logic [30:0] now);
        int unsigned     n;
        int unsigned     cf;
        int unsigned     i;
        longint unsigned rem;
        logic [7:0]      prior;
        bit              stop;
        frame_result_t   res;
        n = (frame_count_reg > FRAME_SLOTS) ? FRAME_SLOTS : frame_count_reg;
        prior = shadow_frame;
        if (op == OP_WRITE)
        begin
            if (idx < n)
            begin
                delay_sum = delay_sum - delay_mem[idx] + dly;
                delay_mem[idx] = dly;
            end
            res.frame = shadow_frame;
            res.changed = 1'b0;
            return res;
        end
        if (!running || n == 0 || delay_sum == 0)
        begin
            // restart at the first frame
            shadow_frame = 8'd0;
            anchor_at = now;
            running = 1'b1;
        end
        else if (now >= anchor_at)
        begin
            // walk forward while the next frame's delay fits in what is left
            rem = (now - anchor_at) % delay_sum;
            cf = shadow_frame;
            stop = 1'b0;
            for (i = 0; i < n && !stop; i++)
            begin
                cf = (cf + 1) % n;
                if (delay_mem[cf] > rem)
                    stop = 1'b1;
                else
                begin
                    shadow_frame = cf[7:0];
                    anchor_at = now;
                    rem = rem - delay_mem[cf];
                    if (rem == 0)
                        stop = 1'b1;
                end
            end
        end
        res.frame = shadow_frame;
        res.changed = (shadow_frame != prior);
        return res;
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 14)
            return 16'hFFFF;
        if (r < 20)
            return 16'($urandom);
        return 16'($urandom_range(1, 40));
    endfunction

    // present one item, hold it until the transfer, then predict its result
    task automatic send_item(input logic op, input logic [7:0] idx, input logic [15:0] dly,
                             input logic [30:0] now, input bit typed,
                             input frame_result_t typed_res);
        frame_result_t res;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        operation   = op;
        frame_index = idx;
        frame_delay = dly;
        time_now    = now;
        do
            @(posedge clk);
        while (!in_ready);
        res = advance_frame(op, idx, dly, now);
        expected_frames.push_back(typed ? typed_res : res);
        items_sent++;
        no_idle = (items_sent >= 700 && items_sent < 1000);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // frame_count is changed only with the unit idle
    task automatic write_frame_count(input logic [8:0] value);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        frame_count_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stimulus
    initial
    begin
        int              k;
        int              r;
        int unsigned     n;
        int              phase_len;
        logic [8:0]      count;
        logic [7:0]      idx;
        longint unsigned t_now;
        longint unsigned inc;
        stim_row_t       row;
        frame_result_t   typed_res;
        frame_result_t   no_res;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operation   = OP_WRITE;
        frame_index = '0;
        frame_delay = '0;
        time_now    = '0;
        errors      = 0;
        items_sent  = 0;
        no_idle     = 1'b0;
        no_res      = '0;
        for (k = 0; k < FRAME_SLOTS; k++)
            delay_mem[k] = '0;
        delay_sum       = 0;
        shadow_frame    = '0;
        anchor_at       = '0;
        running         = 1'b0;
        frame_count_reg = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = DIRECTED[k];
            if (row.kind == ROW_CFG)
                write_frame_count(row.cfg_value);
            else
            begin
                typed_res.frame   = row.exp_frame;
                typed_res.changed = row.exp_changed;
                send_item(row.op, row.idx, row.dly, row.tnow, row.typed, typed_res);
            end
        end

        // random phases: load a delay set, then let time run over it
        items_sent = 0;
        t_now = anchor_at;
        while (items_sent < ITEM_TARGET)
        begin
            // re-anchor now and then, and always when time nears its top
            if (t_now > 64'h7C00_0000 || $urandom_range(0, 2) == 0)
            begin
                write_frame_count(9'd0);
                t_now = $urandom_range(0, 32'h7C00_0000);
                send_item(OP_TIME, 8'($urandom), 16'($urandom), t_now[30:0], 1'b0, no_res);
            end

            r = $urandom_range(0, 99);
            if (r < 8)
                count = 9'd0;
            else if (r < 16)
                count = 9'd256;
            else if (r < 22)
                count = 9'($urandom_range(257, 511));
            else if (r < 40)
                count = 9'($urandom_range(1, 3));
            else if (r < 80)
                count = 9'($urandom_range(4, 16));
            else
                count = 9'($urandom_range(17, 64));
            write_frame_count(count);
            n = (count > FRAME_SLOTS) ? FRAME_SLOTS : count;

            // delay set for the frames in use
            for (k = 0; k < ((n > 32) ? 24 : n); k++)
            begin
                idx = (n > 32) ? 8'($urandom_range(0, n - 1)) : 8'(k);
                send_item(OP_WRITE, idx, pick_delay(), 31'($urandom), 1'b0, no_res);
            end

            phase_len = (n >= 128) ? $urandom_range(12, 24) : $urandom_range(30, 70);
            for (k = 0; k < phase_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    // delay rewrite, now and then past the frame count
                    if (n == 0 || (n < FRAME_SLOTS && $urandom_range(0, 6) == 0))
                        idx = 8'($urandom_range(n, 255));
                    else
                        idx = 8'($urandom_range(0, n - 1));
                    send_item(OP_WRITE, idx, pick_delay(), 31'($urandom), 1'b0, no_res);
                end
                else if (r < 25 && anchor_at != 0)
                begin
                    // time before the anchor
                    send_item(OP_TIME, 8'($urandom), 16'($urandom),
                              31'($urandom_range(0, anchor_at - 1)), 1'b0, no_res);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        inc = $urandom_range(0, 2 * delay_sum + 2);
                    else if (r < 90)
                        inc = $urandom_range(0, 60);
                    else
                        inc = $urandom_range(0, 32'h0100_0000);
                    t_now = t_now + inc;
                    if (t_now > TIME_MAX)
                        t_now = TIME_MAX;
                    send_item(OP_TIME, 8'($urandom), 16'($urandom), t_now[30:0], 1'b0, no_res);
                end
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_result
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("unexpected result: shown_frame %0d frame_changed %0d",
                       shown_frame, frame_changed);
                errors++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (shown_frame !== want.frame)
                begin
                    $error("shown_frame: expected %0d, actual %0d", want.frame, shown_frame);
                    errors++;
                end
                if (frame_changed !== want.changed)
                begin
                    $error("frame_changed: expected %0d, actual %0d",
                           want.changed, frame_changed);
                    errors++;
                end
            end
        end
    end

    // end the run when no transfer has happened for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
